>>> src/msb_first_bit_reader_assert.svh
// assertion macros for the msb-first bit reader
`ifndef MSB_FIRST_BIT_READER_ASSERT_SVH
`define MSB_FIRST_BIT_READER_ASSERT_SVH

`ifndef ASSERT_OFF
// implication or plain property, checked on every rising edge out of reset
`define MFBR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must never hold
`define MFBR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MFBR_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFBR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

>>> src/mfbr_pkg.sv
package mfbr_pkg;

    // byte store geometry
    localparam int STORE_BYTES = 4096;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int PTR_W       = $clog2(STORE_BYTES + 1);

    // bit workspace
    localparam int WS_W        = 64;
    localparam int BITS_W      = 7;
    localparam int FETCH_BYTES = 8;
    localparam int FETCH_CNT_W = 3;
    localparam int TAKE_W      = 4;
    localparam int TOTAL_W     = 8;

    // request and result fields
    localparam int BYTE_W      = 8;
    localparam int N_W         = 6;
    localparam int N_MAX       = 32;
    localparam int VALUE_W     = 32;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_FETCH,
        S_DRAIN,
        S_MERGE,
        S_EMIT
    } mfbr_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic mem_write;
        logic stage_zero;
        logic stage_full;
        logic stage_underrun;
        logic read_fit;
        logic start_refill;
        logic fetch_issue;
        logic merge;
        logic emit;
    } mfbr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_read;
        logic n_zero;
        logic fits;
        logic rem_zero;
        logic store_full;
        logic fetch_last;
        logic out_free;
    } mfbr_sts_t;

endpackage

>>> src/mfbr_if.sv
// request channel
interface mfbr_in_if;
    import mfbr_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [BYTE_W-1:0] byte_in;
    logic [N_W-1:0]    bit_count;

    modport source (output valid, output operation, output byte_in, output bit_count,
                    input ready);
    modport sink   (input valid, input operation, input byte_in, input bit_count,
                    output ready);
endinterface

// result channel
interface mfbr_out_if;
    import mfbr_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               underrun;
    logic               store_full;

    modport source (output valid, output value, output underrun, output store_full,
                    input ready);
    modport sink   (input valid, input value, input underrun, input store_full,
                    output ready);
endinterface

>>> src/msb_first_bit_reader.sv
// msb-first bit reader over a byte store
// item channel: operation 0 appends byte_in to the store, operation 1 reads
//   bit_count bits (0..32, larger counts saturate to 32) msb first
// result channel: exactly one result per request, value right-aligned, with
//   underrun set when a refill found no stored bytes and store_full set when a
//   load found the store full
// one request at a time: loads and reads served from the workspace pass
//   through the evaluate and emit states before the next request can be
//   taken; a read that refills passes through the fetch, drain and merge
//   states in between, with the single store read port gathering 8 bytes
//   one per cycle
// a finished result waits in the output register while the next request is
//   accepted and worked on; if the receiver still stalls when the next result
//   is ready, the block holds it and takes no new request
// reset empties the store and the workspace at once; store contents are not
//   cleared, and bytes at or above the write pointer may be read but are never used
module msb_first_bit_reader (
    input  logic clk,
    input  logic rst_n,
    mfbr_in_if.sink    item,
    mfbr_out_if.source result
);
    import mfbr_pkg::*;

`include "msb_first_bit_reader_assert.svh"

    mfbr_cmd_t cmd;
    mfbr_sts_t sts;
    logic      item_ready;

    assign item.ready = item_ready;

    // sequencer
    mfbr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // store, workspace and result registers
    mfbr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (item.operation),
        .byte_in   (item.byte_in),
        .bit_count (item.bit_count),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

    // checks
    `MFBR_ASSERT(a_emit_free, clk, rst_n, cmd.emit |-> sts.out_free, "result overwritten")
    `MFBR_ASSERT_NEVER(a_write_full, clk, rst_n, cmd.mem_write && sts.store_full, "write past end")
    `MFBR_ASSERT(a_refill_need, clk, rst_n, cmd.start_refill |-> (!sts.rem_zero && !sts.fits), "bad refill")
    `MFBR_ASSERT(a_emit_idle, clk, rst_n, cmd.emit |=> item_ready, "no return to idle")

endmodule

>>> src/mfbr_ctrl.sv
module mfbr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  mfbr_pkg::mfbr_sts_t sts,
    output mfbr_pkg::mfbr_cmd_t cmd
);
    import mfbr_pkg::*;

    mfbr_state_t state_reg;
    mfbr_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_EMIT;
                if (!sts.op_read)
                begin
                    if (sts.store_full)
                    begin
                        cmd.stage_full = 1'b1;
                    end
                    else
                    begin
                        cmd.mem_write  = 1'b1;
                        cmd.stage_zero = 1'b1;
                    end
                end
                else if (sts.n_zero)
                begin
                    cmd.stage_zero = 1'b1;
                end
                else if (sts.fits)
                begin
                    cmd.read_fit = 1'b1;
                end
                else if (sts.rem_zero)
                begin
                    cmd.stage_underrun = 1'b1;
                end
                else
                begin
                    cmd.start_refill = 1'b1;
                    state_next       = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch_issue = 1'b1;
                if (sts.fetch_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/mfbr_datapath.sv
module mfbr_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       operation,
    input  logic [mfbr_pkg::BYTE_W-1:0] byte_in,
    input  logic [mfbr_pkg::N_W-1:0]    bit_count,
    input  mfbr_pkg::mfbr_cmd_t         cmd,
    output mfbr_pkg::mfbr_sts_t         sts,
    mfbr_out_if.source                  result
);
    import mfbr_pkg::*;

    // captured request
    logic              op_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [N_W-1:0]    n_reg;

    // architectural state
    logic [PTR_W-1:0]  wp_reg;
    logic [PTR_W-1:0]  rp_reg;
    logic [WS_W-1:0]   ws_reg;
    logic [BITS_W-1:0] bits_reg;

    // refill gather
    logic [TAKE_W-1:0]      take_reg;
    logic [FETCH_CNT_W-1:0] cnt_reg;
    logic                   pend_reg;
    logic                   use_reg;
    logic [BYTE_W-1:0]      rdata_reg;
    logic [WS_W-1:0]        word_reg;

    // staged result and output register
    logic [VALUE_W-1:0] stage_value_reg;
    logic               stage_under_reg;
    logic               stage_full_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_under_reg;
    logic               out_full_reg;

    logic [BYTE_W-1:0] mem [STORE_BYTES];

    logic [BITS_W-1:0]  n_ext;
    logic [BITS_W-1:0]  top_shift;
    logic [PTR_W-1:0]   rem;
    logic [TAKE_W-1:0]  take_calc;
    logic [ADDR_W-1:0]  fetch_addr;
    logic [WS_W-1:0]    combined;
    logic [TOTAL_W-1:0] total;
    logic               tail_ok;
    logic [VALUE_W-1:0] fit_value;
    logic [VALUE_W-1:0] merge_value;

    // shift amounts, remaining bytes and merged word
    always_comb
    begin
        n_ext       = {1'b0, n_reg};
        top_shift   = BITS_W'(WS_W) - n_ext;
        rem         = wp_reg - rp_reg;
        take_calc   = (rem >= PTR_W'(FETCH_BYTES)) ? TAKE_W'(FETCH_BYTES) : rem[TAKE_W-1:0];
        fetch_addr  = ADDR_W'(rp_reg + PTR_W'(cnt_reg));
        fit_value   = VALUE_W'(ws_reg >> top_shift);
        combined    = ws_reg | (word_reg >> bits_reg);
        merge_value = VALUE_W'(combined >> top_shift);
        total       = TOTAL_W'(bits_reg) + TOTAL_W'({take_reg, 3'b000});
        tail_ok     = total >= TOTAL_W'(n_ext);
    end

    // status toward the controller
    always_comb
    begin
        sts.op_read    = (op_reg == OP_READ);
        sts.n_zero     = (n_reg == '0);
        sts.fits       = (n_ext <= bits_reg);
        sts.rem_zero   = (wp_reg <= rp_reg);
        sts.store_full = (wp_reg == PTR_W'(STORE_BYTES));
        sts.fetch_last = (cnt_reg == '1);
        sts.out_free   = !out_valid_reg || result.ready;
    end

    // request capture, bit count saturated
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            byte_reg <= byte_in;
            n_reg    <= (bit_count > N_W'(N_MAX)) ? N_W'(N_MAX) : bit_count;
        end
    end

    // byte store
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            mem[wp_reg[ADDR_W-1:0]] <= byte_reg;
        end
        if (cmd.fetch_issue)
        begin
            rdata_reg <= mem[fetch_addr];
        end
    end

    // pointers and workspace
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            ws_reg   <= '0;
            bits_reg <= '0;
        end
        else
        begin
            if (cmd.mem_write)
            begin
                wp_reg <= wp_reg + PTR_W'(1);
            end
            if (cmd.read_fit)
            begin
                ws_reg   <= ws_reg << n_ext;
                bits_reg <= bits_reg - n_ext;
            end
            if (cmd.merge)
            begin
                rp_reg <= rp_reg + PTR_W'(take_reg);
                if (tail_ok)
                begin
                    ws_reg   <= word_reg << (n_ext - bits_reg);
                    bits_reg <= BITS_W'(total - TOTAL_W'(n_ext));
                end
                else
                begin
                    ws_reg   <= '0;
                    bits_reg <= '0;
                end
            end
        end
    end

    // refill sequencing: one byte address per cycle, data lands in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.fetch_issue;
            if (cmd.start_refill)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.fetch_issue)
            begin
                cnt_reg <= cnt_reg + FETCH_CNT_W'(1);
            end
        end
    end

    // gather bytes big-endian, zeros past the tail
    always_ff @(posedge clk)
    begin
        if (cmd.start_refill)
        begin
            take_reg <= take_calc;
        end
        if (cmd.fetch_issue)
        begin
            use_reg <= ({1'b0, cnt_reg} < take_reg);
        end
        if (pend_reg)
        begin
            word_reg <= {word_reg[WS_W-BYTE_W-1:0], (use_reg ? rdata_reg : BYTE_W'(0))};
        end
    end

    // staged result
    always_ff @(posedge clk)
    begin
        if (cmd.stage_zero || cmd.stage_full || cmd.stage_underrun)
        begin
            stage_value_reg <= '0;
            stage_under_reg <= cmd.stage_underrun;
            stage_full_reg  <= cmd.stage_full;
        end
        if (cmd.read_fit)
        begin
            stage_value_reg <= fit_value;
            stage_under_reg <= 1'b0;
            stage_full_reg  <= 1'b0;
        end
        if (cmd.merge)
        begin
            stage_value_reg <= merge_value;
            stage_under_reg <= 1'b0;
            stage_full_reg  <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_value_reg <= stage_value_reg;
            out_under_reg <= stage_under_reg;
            out_full_reg  <= stage_full_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.value      = out_value_reg;
    assign result.underrun   = out_under_reg;
    assign result.store_full = out_full_reg;

endmodule

>>> sim/bit_reader_checker.sv
`timescale 1ns / 1ps

// watches both channels, predicts every result and compares it
module bit_reader_checker
(
    input  logic clk,
    input  logic rst_n,
    mfbr_in_if   item,
    mfbr_out_if  result,
    output int   mismatches,
    output int   outstanding,
    output int   underruns_seen,
    output int   drops_seen
);
    import mfbr_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               underrun;
        logic               store_full;
    } bit_result_t;

    // shadow copy of the reader state
    logic [BYTE_W-1:0]  shadow_store [STORE_BYTES];
    logic [PTR_W-1:0]   wr_ptr;
    logic [PTR_W-1:0]   rd_ptr;
    logic [WS_W-1:0]    window;
    logic [BITS_W-1:0]  window_bits;

    bit_result_t predicted_results [$];
    bit_result_t want;
    bit_result_t got;
    int          results_seen;

    // one line per mismatch, printing capped to keep the log short
    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] exp_val,
                                   input logic [VALUE_W-1:0] got_val);
        if (mismatches < 40)
        begin
            $display("mismatch on result %0d, %s: expected %h, got %h",
                     results_seen, what, exp_val, got_val);
        end
        mismatches++;
    endtask

    // expected result of one request, updating the shadow state
    function automatic bit_result_t predict_bits(input logic op,
                                                 input logic [BYTE_W-1:0] data,
                                                 input logic [N_W-1:0] count);
        bit_result_t     res;
        int              n;
        int              avail;
        int              take;
        int              old;
        int              total;
        logic [WS_W-1:0] word;
        logic [WS_W-1:0] merged;

        res = '0;

        // append a byte unless the store is full
        if (op == OP_LOAD)
        begin
            if (wr_ptr < STORE_BYTES)
            begin
                shadow_store[wr_ptr[ADDR_W-1:0]] = data;
                wr_ptr = wr_ptr + 1'b1;
            end
            else
            begin
                res.store_full = 1'b1;
            end
            return res;
        end

        // counts above the maximum saturate, zero reads nothing
        n = (int'(count) > N_MAX) ? N_MAX : int'(count);
        if (n == 0)
            return res;

        // served from the window alone
        if (n <= int'(window_bits))
        begin
            merged      = window >> (WS_W - n);
            res.value   = merged[VALUE_W-1:0];
            window      = window << n;
            window_bits = BITS_W'(int'(window_bits) - n);
            return res;
        end

        // refill needed but nothing stored
        avail = int'(wr_ptr) - int'(rd_ptr);
        if (avail <= 0)
        begin
            res.underrun = 1'b1;
            return res;
        end

        // gather up to eight bytes big-endian, left-aligned
        take = (avail >= FETCH_BYTES) ? FETCH_BYTES : avail;
        word = '0;
        for (int i = 0; i < FETCH_BYTES; i++)
        begin
            word = {word[WS_W-BYTE_W-1:0],
                    (i < take) ? shadow_store[int'(rd_ptr) + i] : {BYTE_W{1'b0}}};
        end
        rd_ptr = rd_ptr + PTR_W'(take);

        // new bytes go right below the bits still held
        old       = int'(window_bits);
        merged    = window | (word >> old);
        total     = old + BYTE_W * take;
        merged    = merged >> (WS_W - n);
        res.value = merged[VALUE_W-1:0];

        // short tail leaves the window empty
        if (total >= n)
        begin
            window      = word << (n - old);
            window_bits = BITS_W'(total - n);
        end
        else
        begin
            window      = '0;
            window_bits = '0;
        end
        return res;
    endfunction

    // predict on each accepted request, compare on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr         = '0;
            rd_ptr         = '0;
            window         = '0;
            window_bits    = '0;
            results_seen   = 0;
            mismatches     = 0;
            underruns_seen = 0;
            drops_seen     = 0;
            predicted_results.delete();
            outstanding   <= 0;
        end
        else
        begin
            if (item.valid && item.ready)
                predicted_results.push_back(predict_bits(item.operation, item.byte_in,
                                                         item.bit_count));

            if (result.valid && result.ready)
            begin
                got.value      = result.value;
                got.underrun   = result.underrun;
                got.store_full = result.store_full;
                if (got.underrun)
                    underruns_seen++;
                if (got.store_full)
                    drops_seen++;

                if (predicted_results.size() == 0)
                begin
                    report_mismatch("result with no request outstanding", '0, got.value);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("value", want.value, got.value);
                    if (got.underrun !== want.underrun)
                        report_mismatch("underrun", VALUE_W'(want.underrun),
                                        VALUE_W'(got.underrun));
                    if (got.store_full !== want.store_full)
                        report_mismatch("store_full", VALUE_W'(want.store_full),
                                        VALUE_W'(got.store_full));
                end
                results_seen++;
            end

            outstanding <= predicted_results.size();
        end
    end

endmodule

>>> sim/tb_msb_first_bit_reader.sv
`timescale 1ns / 1ps

module tb_msb_first_bit_reader;
    import mfbr_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 40;

    logic clk;
    logic rst_n;

    mfbr_in_if  item_ch ();
    mfbr_out_if result_ch ();

    int mismatches;
    int outstanding;
    int underruns_seen;
    int drops_seen;

    int cycle_count = 0;
    int loads_sent;
    int reads_sent;
    bit no_idle;

    msb_first_bit_reader i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    bit_reader_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_ch),
        .result         (result_ch),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .underruns_seen (underruns_seen),
        .drops_seen     (drops_seen)
    );

    // clock
    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("TB_ERROR");
            $finish;
        end
    end

    // offer one request after a random gap and wait until it is taken
    task automatic send_request(input logic op, input logic [BYTE_W-1:0] data,
                                input logic [N_W-1:0] count);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.operation <= op;
        item_ch.byte_in   <= data;
        item_ch.bit_count <= count;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (op == OP_LOAD)
            loads_sent++;
        else
            reads_sent++;
    endtask

    // sender stops until every result is back
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // mostly legal counts, sometimes anything the field holds
    function automatic logic [N_W-1:0] pick_count();
        if ($urandom_range(0, 99) < 15)
            return N_W'($urandom_range(0, 63));
        return N_W'($urandom_range(1, N_MAX));
    endfunction

    // receiver: random stalls, two long holds to back up the block
    initial
    begin
        int gap;
        int taken;
        result_ch.ready <= 1'b0;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken == 300 || taken == 3000)
                gap = LONG_HOLD;
            else
                gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            taken++;
        end
    end

    // stimulus
    initial
    begin
        int  random_sent;
        int  burst_len;
        int  base_underruns;
        bit  load_burst;
        bit  paused_mid;
        logic op;

        loads_sent         = 0;
        reads_sent         = 0;
        no_idle            = 1'b0;
        paused_mid         = 1'b0;
        rst_n             <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.operation <= OP_LOAD;
        item_ch.byte_in   <= '0;
        item_ch.bit_count <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store underrun, zero count
        send_request(OP_READ, 8'h00, 6'd8);
        send_request(OP_READ, 8'hFF, 6'd0);
        // extreme bytes, then a partial refill consumed exactly
        send_request(OP_LOAD, 8'h00, 6'd63);
        send_request(OP_LOAD, 8'hFF, 6'd0);
        send_request(OP_LOAD, 8'hA5, 6'd21);
        send_request(OP_LOAD, 8'h5A, 6'd42);
        send_request(OP_LOAD, 8'h80, 6'd1);
        send_request(OP_LOAD, 8'h01, 6'd32);
        send_request(OP_READ, 8'h00, 6'd1);
        send_request(OP_READ, 8'hFF, 6'd32);
        send_request(OP_READ, 8'h00, 6'd15);
        // saturated count with nothing left
        send_request(OP_READ, 8'h00, 6'd63);
        // full eight-byte refill, exact fit, then a short tail
        for (int i = 0; i < 9; i++)
            send_request(OP_LOAD, BYTE_W'(8'h10 + 8'(i) * 8'h1D), N_W'(i));
        send_request(OP_READ, 8'h00, 6'd40);
        send_request(OP_READ, 8'h00, 6'd32);
        send_request(OP_READ, 8'h00, 6'd17);
        wait_drained();

        // random bursts of loads and reads with some noise
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            no_idle    = ($urandom_range(0, 5) == 0);
            burst_len  = $urandom_range(1, 16);
            load_burst = ($urandom_range(0, 99) < 58);
            for (int k = 0; k < burst_len; k++)
            begin
                op = load_burst ? OP_LOAD : OP_READ;
                if ($urandom_range(0, 9) == 0)
                    op = ~op;
                send_request(op, BYTE_W'($urandom_range(0, 255)),
                             (op == OP_READ) ? pick_count() : N_W'($urandom_range(0, 63)));
            end
            random_sent += burst_len;
            if (!paused_mid && random_sent > RANDOM_ITEMS / 2)
            begin
                paused_mid = 1'b1;
                wait_drained();
            end
        end

        // fill the store to the end and past it
        while (loads_sent < STORE_BYTES + 4)
        begin
            if (loads_sent % 256 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 7) == 0)
                send_request(OP_READ, BYTE_W'($urandom_range(0, 255)), pick_count());
            else
                send_request(OP_LOAD, BYTE_W'($urandom_range(0, 255)),
                             N_W'($urandom_range(0, 63)));
        end

        // drain the full store until it runs dry
        base_underruns = underruns_seen;
        while (underruns_seen < base_underruns + 6)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            send_request(OP_READ, BYTE_W'($urandom_range(0, 255)),
                         ($urandom_range(0, 3) == 0) ? pick_count()
                                                     : N_W'($urandom_range(24, 63)));
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("sent %0d loads and %0d reads in bursts under random and long stalls",
                 loads_sent, reads_sent);
        $display("store filled past its end: %0d dropped loads, %0d underruns",
                 drops_seen, underruns_seen);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/mfbr_pkg.sv
src/mfbr_if.sv
src/mfbr_ctrl.sv
src/mfbr_datapath.sv
src/msb_first_bit_reader.sv
sim/bit_reader_checker.sv
sim/tb_msb_first_bit_reader.sv
